### rtl/core/hysteresis_debounce_presence_top_defines.svh
// Assertion macros for the presence detector checker.
// Included by hdp_checker.sv; no other dependencies.
`ifndef HYSTERESIS_DEBOUNCE_PRESENCE_TOP_DEFINES_SVH
`define HYSTERESIS_DEBOUNCE_PRESENCE_TOP_DEFINES_SVH

// Concurrent check, muted while reset is high.
`define HDP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hdp assertion failed");

// Concurrent check that also runs across reset.
`define HDP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("hdp assertion failed");

`endif

### rtl/core/hdp_pkg.sv
// Shared types and constants for the hysteresis/debounce presence detector.
// No dependencies.
package hdp_pkg;

   localparam int ENERGY_W = 16;
   localparam int TIME_W   = 32;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_OCC_LEVEL = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_VAC_LEVEL = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_OCC_HOLD  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_VAC_HOLD  = CSR_IDX_W'(3);

   localparam logic [ENERGY_W-1:0] OCC_LEVEL_RST = ENERGY_W'(50);
   localparam logic [ENERGY_W-1:0] VAC_LEVEL_RST = ENERGY_W'(30);
   localparam logic [TIME_W-1:0]   OCC_HOLD_RST  = TIME_W'(1000);
   localparam logic [TIME_W-1:0]   VAC_HOLD_RST  = TIME_W'(5000);

   typedef enum logic [1:0] {
      PH_VACANT   = 2'd0,
      PH_DEB_OCC  = 2'd1,
      PH_OCCUPIED = 2'd2,
      PH_DEB_VAC  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      RSN_NONE        = 3'd0,
      RSN_ROSE        = 3'd1,
      RSN_FELL_IN_DEB = 3'd2,
      RSN_OCC_CONFIRM = 3'd3,
      RSN_DROPPED     = 3'd4,
      RSN_ROSE_IN_DEB = 3'd5,
      RSN_VAC_CONFIRM = 3'd6
   } reason_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] occupied_level;
      logic [ENERGY_W-1:0] vacant_level;
      logic [TIME_W-1:0]   occupied_hold_ms;
      logic [TIME_W-1:0]   vacant_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] energy;
      logic [TIME_W-1:0]   now_ms;
   } sample_type;

   typedef struct packed {
      logic       present;
      phase_type  phase;
      reason_type reason;
   } result_type;

endpackage

### rtl/core/hdp_channels.sv
// Valid/ready channel interfaces for samples and results.
// Depends on hdp_pkg.
interface hdp_req_if import hdp_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [ENERGY_W-1:0] energy;
   logic [TIME_W-1:0]   now_ms;

   modport source (output valid, energy, now_ms, input ready);
   modport sink   (input valid, energy, now_ms, output ready);
endinterface

interface hdp_rsp_if;
   logic       valid;
   logic       ready;
   logic       present;
   logic [1:0] phase;
   logic [2:0] reason;

   modport source (output valid, present, phase, reason, input ready);
   modport sink   (input valid, present, phase, reason, output ready);
endinterface

### rtl/core/hysteresis_debounce_presence_top.sv
// A sample is held in the input register; its result goes to the result register when free.
// Throughput: one transaction per cycle while rsp_ch.ready is high; the input register and
// the result register let a new sample enter while a finished result waits on rsp_ch.ready.
// Reset (synchronous, active high): phase vacant, presence cleared, change time zero,
// thresholds and hold times to 50 / 30 / 1000 ms / 5000 ms, both stages empty.
module hysteresis_debounce_presence_top import hdp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   hdp_req_if.sink               req_ch,
   hdp_rsp_if.source             rsp_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   sample_type sample_ff;
   logic       in_valid_ff;
   result_type result;
   result_type out_ff;
   logic       out_valid_ff;
   logic       req_take;
   logic       advance;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   hdp_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   hdp_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .sample (sample_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff.energy <= req_ch.energy;
         sample_ff.now_ms <= req_ch.now_ms;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.present = out_ff.present;
   assign rsp_ch.phase   = out_ff.phase;
   assign rsp_ch.reason  = out_ff.reason;

endmodule

### rtl/core/hdp_cfg.sv
// Configuration register file: thresholds and hold times.
// Depends on hdp_pkg.
module hdp_cfg import hdp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_OCC_LEVEL: cfg_in.occupied_level   = csr_wdata[ENERGY_W-1:0];
            CSR_VAC_LEVEL: cfg_in.vacant_level     = csr_wdata[ENERGY_W-1:0];
            CSR_OCC_HOLD:  cfg_in.occupied_hold_ms = csr_wdata[TIME_W-1:0];
            CSR_VAC_HOLD:  cfg_in.vacant_hold_ms   = csr_wdata[TIME_W-1:0];
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.occupied_level   <= OCC_LEVEL_RST;
         cfg_ff.vacant_level     <= VAC_LEVEL_RST;
         cfg_ff.occupied_hold_ms <= OCC_HOLD_RST;
         cfg_ff.vacant_hold_ms   <= VAC_HOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/hdp_fsm.sv
// Presence state machine: phase, last change time and published flag.
// Depends on hdp_pkg.
module hdp_fsm import hdp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  sample_type sample,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type         phase_ff, phase_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic              present_ff, present_in;
   reason_type        reason;
   logic [TIME_W-1:0] elapsed;
   logic              occ_elapsed;
   logic              vac_elapsed;

   // wrapping difference: an earlier timestamp reads as a long wait
   assign elapsed     = sample.now_ms - change_time_ff;
   assign occ_elapsed = elapsed >= cfg.occupied_hold_ms;
   assign vac_elapsed = elapsed >= cfg.vacant_hold_ms;

   always_comb begin
      phase_in   = phase_ff;
      present_in = present_ff;
      reason     = RSN_NONE;
      unique case (phase_ff)
         PH_VACANT: begin
            if (sample.energy >= cfg.occupied_level) begin
               phase_in = PH_DEB_OCC;
               reason   = RSN_ROSE;
            end
         end
         PH_DEB_OCC: begin
            // fall-back wins over an elapsed hold
            if (sample.energy < cfg.occupied_level) begin
               phase_in = PH_VACANT;
               reason   = RSN_FELL_IN_DEB;
            end else if (occ_elapsed) begin
               phase_in   = PH_OCCUPIED;
               present_in = 1'b1;
               reason     = RSN_OCC_CONFIRM;
            end
         end
         PH_OCCUPIED: begin
            if (sample.energy <= cfg.vacant_level) begin
               phase_in = PH_DEB_VAC;
               reason   = RSN_DROPPED;
            end
         end
         PH_DEB_VAC: begin
            if (sample.energy > cfg.vacant_level) begin
               phase_in = PH_OCCUPIED;
               reason   = RSN_ROSE_IN_DEB;
            end else if (vac_elapsed) begin
               phase_in   = PH_VACANT;
               present_in = 1'b0;
               reason     = RSN_VAC_CONFIRM;
            end
         end
         default: ;
      endcase
      change_time_in = (phase_in != phase_ff) ? sample.now_ms : change_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_VACANT;
         change_time_ff <= '0;
         present_ff     <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         change_time_ff <= change_time_in;
         present_ff     <= present_in;
      end
   end

   assign result.present = present_in;
   assign result.phase   = phase_in;
   assign result.reason  = reason;

endmodule

### rtl/core/hdp_checker.sv
// Port-level checks on the presence detector's result channel, bound to the top level.
// Depends on hdp_pkg and hysteresis_debounce_presence_top_defines.svh.
`include "hysteresis_debounce_presence_top_defines.svh"

module hdp_checker import hdp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_present,
   input logic [1:0] rsp_phase,
   input logic [2:0] rsp_reason
);

   logic       reason_fits_phase;
   logic [5:0] rsp_bits;

   assign rsp_bits = {rsp_present, rsp_phase, rsp_reason};

   // each transition reason lands in exactly one phase
   always_comb begin
      unique case (rsp_reason)
         RSN_ROSE:        reason_fits_phase = rsp_phase == PH_DEB_OCC;
         RSN_FELL_IN_DEB: reason_fits_phase = rsp_phase == PH_VACANT;
         RSN_OCC_CONFIRM: reason_fits_phase = rsp_phase == PH_OCCUPIED;
         RSN_DROPPED:     reason_fits_phase = rsp_phase == PH_DEB_VAC;
         RSN_ROSE_IN_DEB: reason_fits_phase = rsp_phase == PH_OCCUPIED;
         RSN_VAC_CONFIRM: reason_fits_phase = rsp_phase == PH_VACANT;
         RSN_NONE:        reason_fits_phase = 1'b1;
         default:         reason_fits_phase = 1'b0;
      endcase
   end

   `HDP_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_valid)
   `HDP_ASSERT(a_present_tracks_phase, clock, reset, rsp_valid |-> rsp_present == rsp_phase[1])
   `HDP_ASSERT(a_reason_fits_phase, clock, reset, rsp_valid |-> reason_fits_phase)
   `HDP_ASSERT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bits))

endmodule

bind hysteresis_debounce_presence_top hdp_checker u_hdp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_present (rsp_ch.present),
   .rsp_phase   (rsp_ch.phase),
   .rsp_reason  (rsp_ch.reason)
);
